// ===== hw/rtl/rtpb_pkg.sv =====
// Shared constants, field layout and control types for the relay timer controller.
package rtpb_pkg;

  // Channel count and derived widths
  localparam int CHANNELS = 8;
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SEL_W    = (IDX_W > 3) ? IDX_W : 3;
  localparam int CNT_W    = $clog2(CHANNELS + 1);

  // Field widths
  localparam int KIND_W  = 3;
  localparam int CH_W    = 3;
  localparam int SECS_W  = 16;
  localparam int MS_W    = 24;
  localparam int CYC_W   = 16;
  localparam int EL_W    = 26;
  localparam int MODE_W  = 2;
  localparam int LVL_OUT_W = 8;
  localparam int CHG_W   = 4;

  // in_tdata layout, lowest bit up
  localparam int IN_CH_LO    = 0;
  localparam int IN_LVL_LO   = IN_CH_LO + CH_W;
  localparam int IN_SECS_LO  = IN_LVL_LO + 1;
  localparam int IN_PULSE_LO = IN_SECS_LO + SECS_W;
  localparam int IN_ON_LO    = IN_PULSE_LO + MS_W;
  localparam int IN_OFF_LO   = IN_ON_LO + MS_W;
  localparam int IN_CYC_LO   = IN_OFF_LO + MS_W;
  localparam int IN_USED_W   = IN_CYC_LO + CYC_W;
  localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // out_tdata layout, lowest bit up
  localparam int OUT_CHG_LO  = LVL_OUT_W;
  localparam int OUT_ON_LO   = OUT_CHG_LO + CHG_W;
  localparam int OUT_MODE_LO = OUT_ON_LO + 1;
  localparam int OUT_USED_W  = OUT_MODE_LO + MODE_W;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  // Command kinds
  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SET_CH  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET_ALL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TIMER   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PULSE   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_BLINK   = 3'd5;

  // Channel modes
  localparam logic [MODE_W-1:0] MODE_TOGGLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TIMER  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PULSE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BLINK  = 2'd3;

  localparam int MS_PER_SECOND = 1000;
  localparam logic [EL_W-1:0] ELAPSED_MAX = {EL_W{1'b1}};

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // latch a new item, restart the channel walk
    logic step;      // update the channel at the walk index
    logic load_out;  // move the finished result into the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_ch;   // walk index is on the last channel
  } dp_sts_t;

endpackage

// ===== hw/rtl/rtpb_ctrl.sv =====
// Sequencer for the relay controller: accept, channel walk, result hand-off.
module rtpb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output rtpb_pkg::dp_cmd_t cmd,
  input  rtpb_pkg::dp_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  // Commands to the datapath
  always_comb begin
    cmd.load     = in_tvalid && (state_r == ST_IDLE);
    cmd.step     = (state_r == ST_WALK);
    cmd.load_out = (state_r == ST_HOLD) && out_free;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (sts.last_ch) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  // A result is never written over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result overwritten before it was taken");

  // The hold state is reached only from the last channel of a walk
  a_walk_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD && $past(state_r) != ST_HOLD) |->
      ($past(state_r) == ST_WALK && $past(sts.last_ch)))
    else $error("walk ended early");

  // An accepted item always starts a walk
  a_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_WALK))
    else $error("accepted item did not start a walk");
`endif

endmodule

// ===== hw/rtl/rtpb_datapath.sv =====
// Per-channel state, channel walk update, status capture and result register.
module rtpb_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rtpb_pkg::dp_cmd_t               cmd,
  output rtpb_pkg::dp_sts_t               sts,
  input  logic [rtpb_pkg::KIND_W-1:0]     in_tuser,
  input  logic [rtpb_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic [rtpb_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int EW = rtpb_pkg::EL_W;
  localparam int MW = rtpb_pkg::MS_W;
  localparam int CW = rtpb_pkg::CYC_W;
  localparam int NC = rtpb_pkg::CHANNELS;

  // Latched item
  logic [rtpb_pkg::KIND_W-1:0] kind_r;
  logic [rtpb_pkg::CH_W-1:0]   ch_r;
  logic                        level_r;
  logic [rtpb_pkg::SECS_W-1:0] secs_r;
  logic [MW-1:0]               pulse_r, on_in_r, off_in_r;
  logic [CW-1:0]               cyc_in_r;

  // Per-channel state
  logic [rtpb_pkg::MODE_W-1:0] mode_r [NC];
  logic [EW-1:0]               el_r   [NC];
  logic [EW-1:0]               dur_r  [NC];
  logic [MW-1:0]               onl_r  [NC];
  logic [MW-1:0]               offl_r [NC];
  logic [CW-1:0]               cyc_r  [NC];
  logic [NC-1:0]               inon_r;
  logic [NC-1:0]               active_r;
  logic [NC-1:0]               phys_r;

  // Walk and accumulators
  logic [rtpb_pkg::IDX_W-1:0]  idx_r;
  logic [rtpb_pkg::CNT_W-1:0]  acc_r, acc_nxt;
  logic                        st_on_r, st_on_nxt;
  logic [rtpb_pkg::MODE_W-1:0] st_mode_r, st_mode_nxt;

  // Result register
  logic [rtpb_pkg::LVL_OUT_W-1:0] out_lvl_r;
  logic [rtpb_pkg::CHG_W-1:0]     out_chg_r;
  logic                           out_on_r;
  logic [rtpb_pkg::MODE_W-1:0]    out_mode_r;

  // Current channel values and next values
  logic [rtpb_pkg::MODE_W-1:0] rd_mode, mode_nxt;
  logic [EW-1:0]               rd_el, el_nxt, el_inc, limit, dur_nxt, dur_timer;
  logic [MW-1:0]               onl_nxt, offl_nxt;
  logic [CW-1:0]               rd_cyc, cyc_nxt, cyc_dec;
  logic                        rd_inon, inon_nxt, rd_act, act_nxt, rd_phys, phys_nxt;
  logic                        tgt;
  logic [rtpb_pkg::LVL_OUT_W-1:0] levels;
  logic [rtpb_pkg::CNT_W+3:0]  acc_wide;

  assign sts.last_ch = (idx_r == rtpb_pkg::IDX_W'(NC - 1));
  assign tgt = (rtpb_pkg::SEL_W'(idx_r) == rtpb_pkg::SEL_W'(ch_r));

  assign rd_mode = mode_r[idx_r];
  assign rd_el   = el_r[idx_r];
  assign rd_cyc  = cyc_r[idx_r];
  assign rd_inon = inon_r[idx_r];
  assign rd_act  = active_r[idx_r];
  assign rd_phys = phys_r[idx_r];

  // Timer length in ms, constant multiply
  assign dur_timer = EW'(secs_r) * EW'(rtpb_pkg::MS_PER_SECOND);

  // Saturating elapsed count, current phase limit, blink countdown
  assign el_inc  = (rd_el == rtpb_pkg::ELAPSED_MAX) ? rd_el : rd_el + EW'(1);
  assign limit   = rd_inon ? EW'(onl_r[idx_r]) : EW'(offl_r[idx_r]);
  assign cyc_dec = (rd_cyc != '0) ? rd_cyc - CW'(1) : rd_cyc;

  // Update of the channel at the walk index
  always_comb begin
    mode_nxt = rd_mode;
    el_nxt   = rd_el;
    dur_nxt  = dur_r[idx_r];
    onl_nxt  = onl_r[idx_r];
    offl_nxt = offl_r[idx_r];
    cyc_nxt  = rd_cyc;
    inon_nxt = rd_inon;
    act_nxt  = rd_act;
    phys_nxt = rd_phys;
    case (kind_r)
      rtpb_pkg::KIND_TICK: begin
        if (rd_act) begin
          el_nxt = el_inc;
          if (rd_mode == rtpb_pkg::MODE_TIMER || rd_mode == rtpb_pkg::MODE_PULSE) begin
            if (el_inc >= dur_r[idx_r]) begin
              act_nxt  = 1'b0;
              phys_nxt = 1'b0;
            end
          end else if (rd_mode == rtpb_pkg::MODE_BLINK) begin
            if (el_inc >= limit) begin
              el_nxt = '0;
              if (rd_inon) begin
                inon_nxt = 1'b0;
                phys_nxt = 1'b0;
              end else begin
                cyc_nxt = cyc_dec;
                if (cyc_dec == '0) begin
                  act_nxt = 1'b0;
                end else begin
                  inon_nxt = 1'b1;
                  phys_nxt = 1'b1;
                end
              end
            end
          end
        end
      end
      rtpb_pkg::KIND_SET_ALL: begin
        act_nxt  = 1'b0;
        mode_nxt = rtpb_pkg::MODE_TOGGLE;
        phys_nxt = level_r;
      end
      rtpb_pkg::KIND_SET_CH: begin
        if (tgt) begin
          act_nxt  = 1'b0;
          mode_nxt = rtpb_pkg::MODE_TOGGLE;
          phys_nxt = level_r;
        end
      end
      rtpb_pkg::KIND_TIMER: begin
        if (tgt) begin
          mode_nxt = rtpb_pkg::MODE_TIMER;
          act_nxt  = 1'b1;
          el_nxt   = '0;
          dur_nxt  = dur_timer;
          phys_nxt = 1'b1;
        end
      end
      rtpb_pkg::KIND_PULSE: begin
        if (tgt) begin
          mode_nxt = rtpb_pkg::MODE_PULSE;
          act_nxt  = 1'b1;
          el_nxt   = '0;
          dur_nxt  = EW'(pulse_r);
          phys_nxt = 1'b1;
        end
      end
      rtpb_pkg::KIND_BLINK: begin
        if (tgt) begin
          mode_nxt = rtpb_pkg::MODE_BLINK;
          act_nxt  = 1'b1;
          el_nxt   = '0;
          onl_nxt  = on_in_r;
          offl_nxt = off_in_r;
          cyc_nxt  = cyc_in_r;
          inon_nxt = 1'b1;
          phys_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Change count and addressed channel status
  always_comb begin
    acc_nxt     = acc_r + rtpb_pkg::CNT_W'(phys_nxt != rd_phys);
    st_on_nxt   = st_on_r;
    st_mode_nxt = st_mode_r;
    if (tgt) begin
      st_on_nxt   = phys_nxt;
      st_mode_nxt = act_nxt ? mode_nxt : rtpb_pkg::MODE_TOGGLE;
    end
  end

  // Visible relay levels, channels 0 to 7
  always_comb begin
    levels = '0;
    for (int i = 0; i < rtpb_pkg::LVL_OUT_W; i++) begin
      if (i < NC) levels[i] = phys_r[i % NC];
    end
  end

  assign acc_wide = (rtpb_pkg::CNT_W + 4)'(acc_r);

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_tuser;
      ch_r     <= in_tdata[rtpb_pkg::IN_CH_LO +: rtpb_pkg::CH_W];
      level_r  <= in_tdata[rtpb_pkg::IN_LVL_LO];
      secs_r   <= in_tdata[rtpb_pkg::IN_SECS_LO +: rtpb_pkg::SECS_W];
      pulse_r  <= in_tdata[rtpb_pkg::IN_PULSE_LO +: MW];
      on_in_r  <= in_tdata[rtpb_pkg::IN_ON_LO +: MW];
      off_in_r <= in_tdata[rtpb_pkg::IN_OFF_LO +: MW];
      cyc_in_r <= in_tdata[rtpb_pkg::IN_CYC_LO +: CW];
    end
  end

  // Walk index, accumulators, status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      acc_r     <= '0;
      st_on_r   <= 1'b0;
      st_mode_r <= rtpb_pkg::MODE_TOGGLE;
    end else if (cmd.load) begin
      idx_r     <= '0;
      acc_r     <= '0;
      st_on_r   <= 1'b0;
      st_mode_r <= rtpb_pkg::MODE_TOGGLE;
    end else if (cmd.step) begin
      idx_r     <= sts.last_ch ? '0 : idx_r + rtpb_pkg::IDX_W'(1);
      acc_r     <= acc_nxt;
      st_on_r   <= st_on_nxt;
      st_mode_r <= st_mode_nxt;
    end
  end

  // Control part of the channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      phys_r   <= '0;
      for (int i = 0; i < NC; i++) mode_r[i] <= rtpb_pkg::MODE_TOGGLE;
    end else if (cmd.step) begin
      active_r[idx_r] <= act_nxt;
      phys_r[idx_r]   <= phys_nxt;
      mode_r[idx_r]   <= mode_nxt;
    end
  end

  // Counters and lengths
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      el_r[idx_r]   <= el_nxt;
      dur_r[idx_r]  <= dur_nxt;
      onl_r[idx_r]  <= onl_nxt;
      offl_r[idx_r] <= offl_nxt;
      cyc_r[idx_r]  <= cyc_nxt;
      inon_r[idx_r] <= inon_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_lvl_r  <= levels;
      out_chg_r  <= (acc_wide > (rtpb_pkg::CNT_W + 4)'(15)) ? 4'd15 : acc_wide[3:0];
      out_on_r   <= st_on_r;
      out_mode_r <= st_mode_r;
    end
  end

  assign out_tdata = {{(rtpb_pkg::OUT_DATA_W - rtpb_pkg::OUT_USED_W){1'b0}},
                      out_mode_r, out_on_r, out_chg_r, out_lvl_r};

`ifndef SYNTHESIS
  // No more changes than channels in one item
  a_chg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= rtpb_pkg::CNT_W'(NC))
    else $error("change count above channel count");

  // A set-all item leaves every channel inactive once the walk is done
  a_set_all: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && sts.last_ch && kind_r == rtpb_pkg::KIND_SET_ALL) |=> (active_r == '0))
    else $error("channel still active after set-all");

  // Status mode is never reported for a channel that is not addressed
  a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && idx_r == '0 && !tgt) |=> (st_mode_r == rtpb_pkg::MODE_TOGGLE && !st_on_r))
    else $error("status captured from wrong channel");
`endif

endmodule

// ===== hw/rtl/relay_timer_pulse_blink_controller.sv =====
// Top level of the eight-channel relay controller with timer, pulse and blink modes.
// Each item walks all CHANNELS channel entries, one per cycle, through one update unit.
// A new item is taken only after the last result has moved into the output register.
// Reset (rst_n low, synchronous): all channels inactive in toggle mode, relays off,
// no result pending.
module relay_timer_pulse_blink_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // kind[2:0]
  input  logic [rtpb_pkg::KIND_W-1:0]     in_tuser,
  // channel[2:0], level[3], timer_seconds[19:4], pulse_ms[43:20], on_ms[67:44],
  // off_ms[91:68], blink_cycles[107:92], zero fill
  input  logic [rtpb_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // relay_levels[7:0], change_count[11:8], status_on[12], status_mode[14:13], zero fill
  output logic [rtpb_pkg::OUT_DATA_W-1:0] out_tdata
);

  rtpb_pkg::dp_cmd_t cmd;
  rtpb_pkg::dp_sts_t sts;

  rtpb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  rtpb_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the eight-channel relay timer, pulse and blink controller.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rtpb_pkg::*;

  // Kind codes that the block treats as no-ops
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;
  localparam int QUIET_LIMIT = 1000;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CH_W-1:0]   chan;
    logic              level;
    logic [SECS_W-1:0] secs;
    logic [MS_W-1:0]   pulse_ms;
    logic [MS_W-1:0]   on_ms;
    logic [MS_W-1:0]   off_ms;
    logic [CYC_W-1:0]  cycles;
  } relay_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0]    status_mode;
    logic                 status_on;
    logic [CHG_W-1:0]     changes;
    logic [LVL_OUT_W-1:0] levels;
  } relay_status_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [KIND_W-1:0]     in_tuser = '0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Pacing switches for the two sides
  bit pace_input = 1'b1;
  bit pace_output = 1'b1;

  int errors = 0;
  int quiet_cycles = 0;
  relay_status_t status_q[$];

  // Shadow of the per-channel relay state
  logic [MODE_W-1:0] rl_mode[CHANNELS];
  logic              rl_active[CHANNELS];
  logic [EL_W-1:0]   rl_elapsed[CHANNELS];
  logic [EL_W-1:0]   rl_duration[CHANNELS];
  logic [MS_W-1:0]   rl_on_len[CHANNELS];
  logic [MS_W-1:0]   rl_off_len[CHANNELS];
  logic [CYC_W-1:0]  rl_cycles_left[CHANNELS];
  logic              rl_on_phase[CHANNELS];
  logic              rl_level[CHANNELS];
  int                n_changes;

  relay_timer_pulse_blink_controller u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #1 clk = ~clk;

  // Relay drive with change counting
  function automatic void drive_relay(int ch, logic lvl);
    if (rl_level[ch] != lvl) begin
      rl_level[ch] = lvl;
      n_changes++;
    end
  endfunction

  // Direct set puts the channel back in toggle mode
  function automatic void set_direct(int ch, logic lvl);
    rl_active[ch] = 1'b0;
    rl_mode[ch] = MODE_TOGGLE;
    drive_relay(ch, lvl);
  endfunction

  // Applies one command to the shadow state, returns the status it reports
  function automatic relay_status_t next_relay_status(relay_cmd_t c);
    relay_status_t r;
    logic [EL_W-1:0] phase_len;
    logic ch_ok;
    int ch;
    ch = int'(c.chan);
    ch_ok = (ch < CHANNELS);
    n_changes = 0;
    if (c.kind == KIND_TICK) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (rl_active[i]) begin
          if (rl_elapsed[i] != ELAPSED_MAX) rl_elapsed[i]++;
          if (rl_mode[i] == MODE_TIMER || rl_mode[i] == MODE_PULSE) begin
            if (rl_elapsed[i] >= rl_duration[i]) begin
              rl_active[i] = 1'b0;
              drive_relay(i, 1'b0);
            end
          end else if (rl_mode[i] == MODE_BLINK) begin
            phase_len = rl_on_phase[i] ? EL_W'(rl_on_len[i]) : EL_W'(rl_off_len[i]);
            if (rl_elapsed[i] >= phase_len) begin
              rl_elapsed[i] = '0;
              if (rl_on_phase[i]) begin
                rl_on_phase[i] = 1'b0;
                drive_relay(i, 1'b0);
              end else begin
                // count falls after each off phase; zero acts like one
                if (rl_cycles_left[i] != 0) rl_cycles_left[i]--;
                if (rl_cycles_left[i] == 0) begin
                  rl_active[i] = 1'b0;
                end else begin
                  rl_on_phase[i] = 1'b1;
                  drive_relay(i, 1'b1);
                end
              end
            end
          end
        end
      end
    end else if (c.kind == KIND_SET_ALL) begin
      for (int i = 0; i < CHANNELS; i++) set_direct(i, c.level);
    end else if (ch_ok) begin
      case (c.kind)
        KIND_SET_CH: begin
          set_direct(ch, c.level);
        end
        KIND_TIMER, KIND_PULSE: begin
          rl_mode[ch] = (c.kind == KIND_TIMER) ? MODE_TIMER : MODE_PULSE;
          rl_active[ch] = 1'b1;
          rl_elapsed[ch] = '0;
          rl_duration[ch] = (c.kind == KIND_TIMER) ? EL_W'(c.secs * MS_PER_SECOND)
                                                   : EL_W'(c.pulse_ms);
          drive_relay(ch, 1'b1);
        end
        KIND_BLINK: begin
          rl_mode[ch] = MODE_BLINK;
          rl_active[ch] = 1'b1;
          rl_elapsed[ch] = '0;
          rl_on_len[ch] = c.on_ms;
          rl_off_len[ch] = c.off_ms;
          rl_cycles_left[ch] = c.cycles;
          rl_on_phase[ch] = 1'b1;
          drive_relay(ch, 1'b1);
        end
        default: ;
      endcase
    end
    r = '0;
    for (int i = 0; i < CHANNELS && i < LVL_OUT_W; i++) r.levels[i] = rl_level[i];
    r.changes = (n_changes > 15) ? 4'd15 : CHG_W'(n_changes);
    r.status_on = ch_ok && rl_level[ch];
    r.status_mode = (ch_ok && rl_active[ch]) ? rl_mode[ch] : MODE_TOGGLE;
    return r;
  endfunction

  function automatic relay_cmd_t mk_cmd(logic [KIND_W-1:0] k, int ch, int lvl, int secs,
                                        int pulse, int on_len, int off_len, int cyc);
    relay_cmd_t c;
    c.kind = k;
    c.chan = CH_W'(ch);
    c.level = lvl[0];
    c.secs = SECS_W'(secs);
    c.pulse_ms = MS_W'(pulse);
    c.on_ms = MS_W'(on_len);
    c.off_ms = MS_W'(off_len);
    c.cycles = CYC_W'(cyc);
    return c;
  endfunction

  // Random command, mostly short lengths so timed phases finish under ticks
  function automatic relay_cmd_t rand_cmd();
    relay_cmd_t c;
    int pick;
    c.chan = CH_W'($urandom_range(0, 7));
    c.level = 1'($urandom_range(0, 1));
    c.secs = SECS_W'($urandom_range(0, 16'hFFFF));
    c.pulse_ms = MS_W'($urandom_range(0, 24'hFFFFFF));
    c.on_ms = MS_W'($urandom_range(0, 24'hFFFFFF));
    c.off_ms = MS_W'($urandom_range(0, 24'hFFFFFF));
    c.cycles = CYC_W'($urandom_range(0, 16'hFFFF));
    pick = $urandom_range(0, 99);
    if (pick < 44) c.kind = KIND_TICK;
    else if (pick < 54) c.kind = KIND_SET_CH;
    else if (pick < 57) c.kind = KIND_SET_ALL;
    else if (pick < 66) c.kind = KIND_TIMER;
    else if (pick < 78) c.kind = KIND_PULSE;
    else if (pick < 95) c.kind = KIND_BLINK;
    else c.kind = pick[0] ? KIND_SPARE_A : KIND_SPARE_B;
    if ($urandom_range(0, 9) != 0) begin
      c.secs = ($urandom_range(0, 3) == 0) ? 16'd1 : 16'd0;
      c.pulse_ms = MS_W'($urandom_range(0, 8));
      c.on_ms = MS_W'($urandom_range(0, 5));
      c.off_ms = MS_W'($urandom_range(0, 5));
      c.cycles = CYC_W'($urandom_range(0, 4));
    end
    return c;
  endfunction

  // Presents one item, waits for its handshake and queues its expected status
  task automatic send_cmd(relay_cmd_t c);
    logic [IN_DATA_W-1:0] word;
    int gap;
    gap = 0;
    if (pace_input) while ($urandom_range(0, 99) < 26) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word = '0;
    word[IN_CH_LO +: CH_W] = c.chan;
    word[IN_LVL_LO] = c.level;
    word[IN_SECS_LO +: SECS_W] = c.secs;
    word[IN_PULSE_LO +: MS_W] = c.pulse_ms;
    word[IN_ON_LO +: MS_W] = c.on_ms;
    word[IN_OFF_LO +: MS_W] = c.off_ms;
    word[IN_CYC_LO +: CYC_W] = c.cycles;
    in_tvalid <= 1'b1;
    in_tuser <= c.kind;
    in_tdata <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    status_q.push_back(next_relay_status(c));
  endtask

  // Sender holds off until every queued status has come back
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_direct_set();
    send_cmd(mk_cmd(KIND_SET_ALL, 0, 1, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(KIND_SET_CH, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(KIND_SET_CH, 7, 1, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(KIND_SET_ALL, 3, 0, 0, 0, 0, 0, 0));
  endtask

  // Unused kinds with every field bit set must change nothing
  task automatic test_spare_kinds();
    send_cmd(mk_cmd(KIND_SPARE_A, 7, 1, 'hFFFF, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 'hFFFF));
    send_cmd(mk_cmd(KIND_SPARE_B, 5, 1, 'hFFFF, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 'hFFFF));
  endtask

  // Zero lengths end on the first tick; long ones outlast both ticks, and the long timer ends with a set
  task automatic test_timer_pulse();
    send_cmd(mk_cmd(KIND_PULSE, 1, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(KIND_TIMER, 2, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(KIND_PULSE, 3, 0, 0, 2, 0, 0, 0));
    send_cmd(mk_cmd(KIND_TIMER, 4, 0, 'hFFFF, 0, 0, 0, 0));
    send_cmd(mk_cmd(KIND_PULSE, 5, 0, 0, 'hFFFFFF, 0, 0, 0));
    send_cmd(mk_cmd(KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(KIND_SET_CH, 4, 0, 0, 0, 0, 0, 0));
  endtask

  // Blink with a zero count, a zero on phase, and the largest settings
  task automatic test_blink();
    send_cmd(mk_cmd(KIND_BLINK, 6, 0, 0, 0, 1, 1, 0));
    send_cmd(mk_cmd(KIND_BLINK, 7, 0, 0, 0, 0, 2, 2));
    repeat (6) send_cmd(mk_cmd(KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(KIND_BLINK, 0, 0, 0, 0, 'hFFFFFF, 'hFFFFFF, 'hFFFF));
    send_cmd(mk_cmd(KIND_SET_ALL, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_mix();
    repeat (350) send_cmd(rand_cmd());
  endtask

  // Back-to-back traffic, neither side idles
  task automatic test_full_rate();
    pace_input = 1'b0;
    pace_output = 1'b0;
    repeat (100) send_cmd(rand_cmd());
    pace_input = 1'b1;
    pace_output = 1'b1;
  endtask

  // Sender drains the pipe mid-stream, then resumes
  task automatic test_drain_pause();
    repeat (20) send_cmd(rand_cmd());
    wait_all_results();
    repeat (80) send_cmd(rand_cmd());
  endtask

  task automatic check_field(string name, int exp_val, int got_val);
    if (exp_val != got_val) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, got_val);
    end
  endtask

  // Output side backpressure
  always @(posedge clk) out_tready <= !pace_output || ($urandom_range(0, 99) >= 26);

  // Result checker
  always @(posedge clk) begin
    relay_status_t exp_st;
    if (rst_n && out_tvalid && out_tready) begin
      if (status_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_tdata);
      end else begin
        exp_st = status_q.pop_front();
        check_field("relay_levels", int'(exp_st.levels), int'(out_tdata[LVL_OUT_W-1:0]));
        check_field("change_count", int'(exp_st.changes),
                    int'(out_tdata[OUT_CHG_LO +: CHG_W]));
        check_field("status_on", int'(exp_st.status_on), int'(out_tdata[OUT_ON_LO]));
        check_field("status_mode", int'(exp_st.status_mode),
                    int'(out_tdata[OUT_MODE_LO +: MODE_W]));
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      rl_mode[i] = MODE_TOGGLE;
      rl_active[i] = 1'b0;
      rl_elapsed[i] = '0;
      rl_duration[i] = '0;
      rl_on_len[i] = '0;
      rl_off_len[i] = '0;
      rl_cycles_left[i] = '0;
      rl_on_phase[i] = 1'b0;
      rl_level[i] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_direct_set();
    test_spare_kinds();
    test_timer_pulse();
    test_blink();
    test_random_mix();
    test_full_rate();
    test_drain_pause();

    // Let any stray result show up past the block latency
    wait_all_results();
    repeat (CHANNELS + 4) @(posedge clk);
    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
